### rtl/frg_pkg.sv
// Shared constants and controller/datapath interface types for the fraction reducer.
`default_nettype none
package frg_pkg;

	localparam int VALUE_BITS = 31;
	localparam int SHIFT_BITS = $clog2(VALUE_BITS);
	localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
	localparam int STATUS_BITS = 2;

	typedef logic [VALUE_BITS-1:0]  value_t;
	typedef logic [STATUS_BITS-1:0] status_t;

	localparam status_t STATUS_REDUCED = 2'd0;
	localparam status_t STATUS_SIMPLE  = 2'd1;
	localparam status_t STATUS_INVALID = 2'd2;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic scale;
		logic div_start;
		logic div_sel_den;
		logic cap_num;
		logic cap_den;
		logic out_load;
	} frg_cmd_t;

	typedef struct packed {
		logic inv;
		logic gcd_eq;
		logic div_done;
	} frg_sts_t;

endpackage
`default_nettype wire

### rtl/fraction_reduce_gcd_core.sv
// Fraction reducer: input word in, GCD and reduced pair out.
//
// Input channel: in_valid/in_ready carry numerator and denominator.
// Output channel: out_valid/out_ready carry reduced_numerator,
// reduced_denominator, common_divisor and status (0 reduced, 1 already
// simplified, 2 invalid because an input is zero).
// One word is worked on at a time; in_ready is high only while idle.
// A zero input goes from acceptance through the check state straight to the
// result. Any other word runs the binary GCD loop (each step halves an even
// operand or halves the difference of two odd ones), then two restoring
// divisions on one shared divider, then the hand-off to the output
// register.
// The result sits in an output register, so a new word is taken while an
// earlier result still waits; if the receiver stalls, the following
// result holds in the datapath until the output register frees up.
// Reset (arst_n low) returns the controller to idle and drops out_valid.
`default_nettype none
module fraction_reduce_gcd_core import frg_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire value_t numerator,
	input  wire value_t denominator,
	output logic        out_valid,
	input  wire logic   out_ready,
	output value_t      reduced_numerator,
	output value_t      reduced_denominator,
	output value_t      common_divisor,
	output status_t     status
);

	frg_cmd_t cmd;
	frg_sts_t sts;

	frg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	frg_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.numerator           (numerator),
		.denominator         (denominator),
		.reduced_numerator   (reduced_numerator),
		.reduced_denominator (reduced_denominator),
		.common_divisor      (common_divisor),
		.status              (status)
	);

endmodule
`default_nettype wire

### rtl/frg_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module frg_div import frg_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire value_t dividend,
	input  wire value_t divisor,
	output logic        done,
	output value_t      quotient
);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	value_t              rem_q;
	value_t              quo_q;
	value_t              dvs_q;
	logic [VALUE_BITS:0] trial;
	logic [VALUE_BITS:0] diff;
	logic                take;

	always_comb begin
		trial = {rem_q, quo_q[VALUE_BITS-1]};
		diff  = trial - {1'b0, dvs_q};
		take  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out of the top of quo_q while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
			quo_q <= {quo_q[VALUE_BITS-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### rtl/frg_datapath.sv
// Datapath: operand registers, binary GCD step, shared divider and result register.
`default_nettype none
module frg_datapath import frg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire frg_cmd_t cmd,
	output frg_sts_t      sts,
	input  wire value_t   numerator,
	input  wire value_t   denominator,
	output value_t        reduced_numerator,
	output value_t        reduced_denominator,
	output value_t        common_divisor,
	output status_t       status
);

	value_t                num_q;
	value_t                den_q;
	value_t                a_q;
	value_t                b_q;
	logic [SHIFT_BITS-1:0] k_q;
	value_t                g_q;
	value_t                qn_q;
	value_t                qd_q;
	logic                  inv_q;
	value_t                rn_q;
	value_t                rd_q;
	value_t                cd_q;
	status_t               st_q;
	value_t                a_m_b;
	value_t                b_m_a;
	logic                  div_done;
	value_t                div_quo;

	always_comb begin
		a_m_b = a_q - b_q;
		b_m_a = b_q - a_q;
	end

	frg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_sel_den ? den_q : num_q),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= numerator;
			den_q <= denominator;
			a_q   <= numerator;
			b_q   <= denominator;
			k_q   <= '0;
			inv_q <= (numerator == '0) || (denominator == '0);
		end else if (cmd.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_m_b >> 1;
			end else begin
				b_q <= b_m_a >> 1;
			end
		end
		if (cmd.scale)
			g_q <= a_q << k_q;
		if (cmd.cap_num)
			qn_q <= div_quo;
		if (cmd.cap_den)
			qd_q <= div_quo;
		if (cmd.out_load) begin
			if (inv_q) begin
				rn_q <= '0;
				rd_q <= '0;
				cd_q <= '0;
				st_q <= STATUS_INVALID;
			end else begin
				rn_q <= qn_q;
				rd_q <= qd_q;
				cd_q <= g_q;
				st_q <= (g_q == VALUE_BITS'(1)) ? STATUS_SIMPLE : STATUS_REDUCED;
			end
		end
	end

	always_comb begin
		sts.inv      = inv_q;
		sts.gcd_eq   = (a_q == b_q);
		sts.div_done = div_done;
	end

	assign reduced_numerator   = rn_q;
	assign reduced_denominator = rd_q;
	assign common_divisor      = cd_q;
	assign status              = st_q;

endmodule
`default_nettype wire

### rtl/frg_ctrl.sv
// Controller state machine: sequences load, GCD loop, two divisions and result hand-off.
`default_nettype none
module frg_ctrl import frg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire frg_sts_t sts,
	output frg_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_GCD,
		ST_SCALE,
		ST_DIVN_GO,
		ST_DIVN_WAIT,
		ST_DIVD_GO,
		ST_DIVD_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:      cmd.load = in_valid;
			ST_CHECK:     ;
			ST_GCD:       cmd.gcd_step = !sts.gcd_eq;
			ST_SCALE:     cmd.scale = 1'b1;
			ST_DIVN_GO:   cmd.div_start = 1'b1;
			ST_DIVN_WAIT: cmd.cap_num = sts.div_done;
			ST_DIVD_GO: begin
				cmd.div_start   = 1'b1;
				cmd.div_sel_den = 1'b1;
			end
			ST_DIVD_WAIT: cmd.cap_den = sts.div_done;
			ST_FINISH:    cmd.out_load = out_free;
			default:      ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// raise on a new result, drop once the word is taken
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_CHECK;
				end
				ST_CHECK:     state_q <= sts.inv ? ST_FINISH : ST_GCD;
				ST_GCD: begin
					if (sts.gcd_eq)
						state_q <= ST_SCALE;
				end
				ST_SCALE:     state_q <= ST_DIVN_GO;
				ST_DIVN_GO:   state_q <= ST_DIVN_WAIT;
				ST_DIVN_WAIT: begin
					if (sts.div_done)
						state_q <= ST_DIVD_GO;
				end
				ST_DIVD_GO:   state_q <= ST_DIVD_WAIT;
				ST_DIVD_WAIT: begin
					if (sts.div_done)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold until the result register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### rtl/frg_checker.sv
// Port-level checker for the fraction reducer, bound to the top level.
`default_nettype none
module frg_checker import frg_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   in_valid,
	input wire logic   in_ready,
	input wire logic   out_valid,
	input wire logic   out_ready,
	input wire value_t reduced_numerator,
	input wire value_t reduced_denominator,
	input wire value_t common_divisor,
	input wire status_t status
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	// one word in flight: no acceptance in the cycle after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_INVALID |->
		reduced_numerator == '0 && reduced_denominator == '0 && common_divisor == '0)
		else $error("invalid result carries non-zero fields");

	a_simple_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_SIMPLE |-> common_divisor == VALUE_BITS'(1))
		else $error("already-simplified result with divisor not one");

	a_reduced_gt1: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_REDUCED |->
		common_divisor > VALUE_BITS'(1) && reduced_numerator != '0
		&& reduced_denominator != '0)
		else $error("reduced result inconsistent");

endmodule

bind fraction_reduce_gcd_core frg_checker u_frg_checker (.*);
`default_nettype wire
